// ===== rtl/sspg_pkg.sv =====
package sspg_pkg;

    localparam int CLOCK_W      = 29;
    localparam int USTEP_W      = 16;
    localparam int RPM_W        = 16;
    localparam int SPEED_W      = 15;
    localparam int STEPS_W      = 31;
    localparam int NUM_W        = 35;
    localparam int DEN_W        = 32;
    localparam int DIV_CNT_W    = $clog2(NUM_W);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 29;
    localparam int CMD_W        = 3;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 24;

    localparam int PERIOD_WIDTH_DEF     = 32;
    localparam int STEP_COUNT_WIDTH_DEF = 32;

    localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET   = 29'd250000000;
    localparam logic [USTEP_W-1:0] MICROSTEPS_RESET = 16'd12800;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MICROSTEPS = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_MOVE_RPM   = 3'd1,
        CMD_MOVE_STEPS = 3'd2,
        CMD_STOP       = 3'd3,
        CMD_SET_RPM    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic needs_div;
        logic div_busy;
    } dp_status_t;

endpackage

// ===== rtl/sspg_div.sv =====
module sspg_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sspg_pkg::NUM_W-1:0]    num,
    input  logic [sspg_pkg::DEN_W-1:0]    den,
    output logic                          busy,
    output logic [sspg_pkg::NUM_W-1:0]    quotient
);

    logic                              busy_reg, busy_next;
    logic [sspg_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [sspg_pkg::DEN_W-1:0]        rem_reg, rem_next;
    logic [sspg_pkg::DEN_W-1:0]        den_reg, den_next;
    logic [sspg_pkg::NUM_W-1:0]        quo_reg, quo_next;
    logic [sspg_pkg::DEN_W:0]          trial;
    logic                              fits;

    assign trial = {rem_reg, quo_reg[sspg_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = sspg_pkg::DIV_CNT_W'(sspg_pkg::NUM_W - 1);
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? sspg_pkg::DEN_W'(trial - {1'b0, den_reg})
                            : trial[sspg_pkg::DEN_W-1:0];
            quo_next = {quo_reg[sspg_pkg::NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/sspg_dp.sv =====
module sspg_dp
#(
    parameter int PERIOD_WIDTH     = sspg_pkg::PERIOD_WIDTH_DEF,
    parameter int STEP_COUNT_WIDTH = sspg_pkg::STEP_COUNT_WIDTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  sspg_pkg::ctrl_cmd_t                cmd,
    output sspg_pkg::dp_status_t               status,
    input  logic [sspg_pkg::CMD_W-1:0]         s_tuser,
    input  logic [sspg_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               cfg_we,
    input  logic [sspg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sspg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [sspg_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int HALF_W = (STEP_COUNT_WIDTH > sspg_pkg::STEPS_W) ? STEP_COUNT_WIDTH
                                                                   : sspg_pkg::STEPS_W;
    localparam int QSAT_W = (PERIOD_WIDTH > sspg_pkg::NUM_W) ? PERIOD_WIDTH : sspg_pkg::NUM_W;

    sspg_pkg::cmd_t                       in_cmd;
    logic [sspg_pkg::RPM_W-1:0]           in_rpm;
    logic                                 in_cw;
    logic [sspg_pkg::STEPS_W-1:0]         in_steps;

    logic [sspg_pkg::CLOCK_W-1:0]         clock_hz_reg;
    logic [sspg_pkg::USTEP_W-1:0]         ustep_reg;

    logic [PERIOD_WIDTH-1:0]              tick_reg, tick_next;
    logic [PERIOD_WIDTH-1:0]              period_reg, period_next;
    logic [STEP_COUNT_WIDTH-1:0]          halves_reg, halves_next;
    logic                                 fixed_reg, fixed_next;
    logic                                 pulse_reg, pulse_next;
    logic                                 done_reg, done_next;
    logic                                 timer_reg, timer_next;
    logic                                 enabled_reg, enabled_next;
    logic                                 dir_reg, dir_next;
    logic [sspg_pkg::SPEED_W-1:0]         rpm_reg, rpm_next;

    logic                                 rpm_bad, steps_bad;
    logic                                 do_stop, do_start, do_tick;
    logic [sspg_pkg::SPEED_W-1:0]         speed;
    logic [sspg_pkg::USTEP_W-1:0]         ustep_eff;
    logic [sspg_pkg::DEN_W-2:0]           prod;
    logic [sspg_pkg::DEN_W-1:0]           den;
    logic [sspg_pkg::NUM_W-1:0]           num;
    logic [sspg_pkg::NUM_W-1:0]           quotient;
    logic                                 div_busy;
    logic [QSAT_W-1:0]                    q_ext, q_cap, q_sat;
    logic [HALF_W-1:0]                    h_ext, h_cap, h_sat;
    logic [PERIOD_WIDTH:0]                tick_inc;

    assign in_cmd   = sspg_pkg::cmd_t'(s_tuser);
    assign in_rpm   = s_tdata[15:0];
    assign in_cw    = s_tdata[16];
    assign in_steps = s_tdata[47:17];

    assign rpm_bad   = in_rpm[sspg_pkg::RPM_W-1] || (in_rpm == '0);
    assign steps_bad = in_steps[sspg_pkg::STEPS_W-1] || (in_steps == '0) || (rpm_reg == '0);

    always_comb
    begin
        status.div_busy  = div_busy;
        status.needs_div = 1'b0;
        case (in_cmd)
            sspg_pkg::CMD_MOVE_RPM:   status.needs_div = !rpm_bad;
            sspg_pkg::CMD_MOVE_STEPS: status.needs_div = !steps_bad;
            default:                  status.needs_div = 1'b0;
        endcase
    end

    assign do_start = cmd.accept && status.needs_div;
    assign do_tick  = cmd.accept && (in_cmd == sspg_pkg::CMD_TICK) && timer_reg;
    assign do_stop  = cmd.accept && ((in_cmd == sspg_pkg::CMD_STOP)
                    || ((in_cmd == sspg_pkg::CMD_MOVE_RPM) && rpm_bad)
                    || ((in_cmd == sspg_pkg::CMD_MOVE_STEPS) && steps_bad));

    // half-period = clock_hz*60 / (speed*microsteps*2)
    assign speed     = (in_cmd == sspg_pkg::CMD_MOVE_RPM) ? in_rpm[sspg_pkg::SPEED_W-1:0]
                                                          : rpm_reg;
    assign ustep_eff = (ustep_reg == '0) ? sspg_pkg::USTEP_W'(1) : ustep_reg;
    assign prod      = (sspg_pkg::DEN_W-1)'(speed) * (sspg_pkg::DEN_W-1)'(ustep_eff);
    assign den       = {prod, 1'b0};
    assign num       = (sspg_pkg::NUM_W'(clock_hz_reg) << 6) - (sspg_pkg::NUM_W'(clock_hz_reg) << 2);

    sspg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (do_start),
        .num      (num),
        .den      (den),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign q_ext = QSAT_W'(quotient);
    assign q_cap = QSAT_W'({PERIOD_WIDTH{1'b1}});
    always_comb
    begin
        if (q_ext == '0)
        begin
            q_sat = QSAT_W'(1);
        end
        else if (q_ext > q_cap)
        begin
            q_sat = q_cap;
        end
        else
        begin
            q_sat = q_ext;
        end
    end

    assign h_ext = HALF_W'({in_steps[sspg_pkg::STEPS_W-2:0], 1'b0});
    assign h_cap = HALF_W'({STEP_COUNT_WIDTH{1'b1}});
    assign h_sat = (h_ext > h_cap) ? h_cap : h_ext;

    assign tick_inc = {1'b0, tick_reg} + 1'b1;

    always_comb
    begin
        tick_next    = tick_reg;
        period_next  = period_reg;
        halves_next  = halves_reg;
        fixed_next   = fixed_reg;
        pulse_next   = pulse_reg;
        done_next    = done_reg;
        timer_next   = timer_reg;
        enabled_next = enabled_reg;
        dir_next     = dir_reg;
        rpm_next     = rpm_reg;

        if (do_tick)
        begin
            if (tick_inc >= {1'b0, period_reg})
            begin
                tick_next = '0;
                if (!pulse_reg)
                begin
                    pulse_next = 1'b1;
                end
                else
                begin
                    pulse_next = 1'b0;
                    if (fixed_reg)
                    begin
                        if (halves_reg <= STEP_COUNT_WIDTH'(2))
                        begin
                            halves_next = '0;
                            timer_next  = 1'b0;
                            fixed_next  = 1'b0;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            halves_next = halves_reg - STEP_COUNT_WIDTH'(2);
                        end
                    end
                end
            end
            else
            begin
                tick_next = tick_inc[PERIOD_WIDTH-1:0];
            end
        end

        if (do_stop)
        begin
            timer_next   = 1'b0;
            tick_next    = '0;
            pulse_next   = 1'b0;
            enabled_next = 1'b0;
            halves_next  = '0;
            fixed_next   = 1'b0;
            done_next    = 1'b0;
        end

        // period itself lands when the divider finishes
        if (do_start)
        begin
            dir_next     = in_cw;
            tick_next    = '0;
            timer_next   = 1'b1;
            enabled_next = 1'b1;
            done_next    = 1'b0;
            pulse_next   = 1'b0;
            if (in_cmd == sspg_pkg::CMD_MOVE_RPM)
            begin
                rpm_next    = in_rpm[sspg_pkg::SPEED_W-1:0];
                fixed_next  = 1'b0;
                halves_next = '0;
            end
            else
            begin
                fixed_next  = 1'b1;
                halves_next = h_sat[STEP_COUNT_WIDTH-1:0];
            end
        end

        if (cmd.accept && (in_cmd == sspg_pkg::CMD_SET_RPM) && !in_rpm[sspg_pkg::RPM_W-1])
        begin
            rpm_next = in_rpm[sspg_pkg::SPEED_W-1:0];
        end

        if (cmd.finish)
        begin
            period_next = q_sat[PERIOD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= sspg_pkg::CLOCK_HZ_RESET;
            ustep_reg    <= sspg_pkg::MICROSTEPS_RESET;
            tick_reg     <= '0;
            period_reg   <= PERIOD_WIDTH'(1);
            halves_reg   <= '0;
            fixed_reg    <= 1'b0;
            pulse_reg    <= 1'b0;
            done_reg     <= 1'b0;
            timer_reg    <= 1'b0;
            enabled_reg  <= 1'b0;
            dir_reg      <= 1'b0;
            rpm_reg      <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == sspg_pkg::CFG_CLOCK_HZ))
            begin
                clock_hz_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == sspg_pkg::CFG_MICROSTEPS))
            begin
                ustep_reg <= cfg_data[sspg_pkg::USTEP_W-1:0];
            end
            tick_reg    <= tick_next;
            period_reg  <= period_next;
            halves_reg  <= halves_next;
            fixed_reg   <= fixed_next;
            pulse_reg   <= pulse_next;
            done_reg    <= done_next;
            timer_reg   <= timer_next;
            enabled_reg <= enabled_next;
            dir_reg     <= dir_next;
            rpm_reg     <= rpm_next;
        end
    end

    assign m_tdata = {4'b0, rpm_reg, done_reg, timer_reg, !enabled_reg, dir_reg, pulse_reg};

    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        timer_reg |-> (period_reg != '0))
        else $error("timer running with zero half-period");

    a_done_stops_timer: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !timer_reg)
        else $error("move complete while timer runs");

    a_fixed_needs_timer: assert property (@(posedge clk) disable iff (!rst_n)
        fixed_reg |-> timer_reg)
        else $error("fixed move without running timer");

    a_pulse_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_reg |-> enabled_reg)
        else $error("step pulse high with driver disabled");

endmodule

// ===== rtl/sspg_ctrl.sv =====
module sspg_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  sspg_pkg::dp_status_t   status,
    output sspg_pkg::ctrl_cmd_t    cmd
);

    sspg_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_space;

    assign out_space = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sspg_pkg::ST_IDLE:
            begin
                if (s_tvalid && out_space && status.needs_div)
                begin
                    state_next = sspg_pkg::ST_DIVIDE;
                end
            end
            sspg_pkg::ST_DIVIDE:
            begin
                if (!status.div_busy)
                begin
                    state_next = sspg_pkg::ST_FINISH;
                end
            end
            sspg_pkg::ST_FINISH:
            begin
                if (out_space)
                begin
                    state_next = sspg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sspg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            sspg_pkg::ST_IDLE:
            begin
                s_tready   = out_space;
                cmd.accept = s_tvalid && out_space;
            end
            sspg_pkg::ST_FINISH:
            begin
                cmd.finish = out_space;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        m_valid_next = (m_valid_reg && !m_tready)
                     || (cmd.accept && !status.needs_div)
                     || cmd.finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sspg_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    a_no_result_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sspg_pkg::ST_DIVIDE) |-> !m_valid_reg)
        else $error("result pending during division");

    a_finish_follows_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sspg_pkg::ST_FINISH) |->
            ($past(state_reg) == sspg_pkg::ST_DIVIDE || $past(state_reg) == sspg_pkg::ST_FINISH))
        else $error("finish entered without division");

endmodule

// ===== rtl/stepper_step_pulse_generator_core.sv =====
// Step/direction pulse generator.
// Input stream s_*: one command per beat. s_tuser = cmd (tick, move at rpm,
// move steps, stop, set target rpm); s_tdata carries rpm, clockwise, step_count.
// Output stream m_*: exactly one beat per command, the output levels after it.
// Config channel cfg_*: index 0 clock_hz, 1 microsteps_per_rev; write only
// while idle. cfg_ready is always high.
// Tick, stop, set-rpm and rejected moves give their result the cycle
// after the beat; one such command per cycle while m_tready stays high.
// A move that starts runs the 35-step restoring divider for the half-period;
// its result follows the quotient, with one command in flight at a time.
// If m_tready is low, the pending result holds and s_tready drops until it is
// taken, so no beat is lost.
// Reset: timer stopped, step low, driver disabled, direction counterclockwise,
// target rpm 0, clock_hz 250000000, microsteps 12800.
module stepper_step_pulse_generator_core
#(
    parameter int PERIOD_WIDTH     = sspg_pkg::PERIOD_WIDTH_DEF,
    parameter int STEP_COUNT_WIDTH = sspg_pkg::STEP_COUNT_WIDTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [47:17] step_count, [16] clockwise, [15:0] rpm
    input  logic [sspg_pkg::IN_DATA_W-1:0]     s_tdata,
    // [2:0] cmd
    input  logic [sspg_pkg::CMD_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] step_level, [1] dir_level, [2] enable_n, [3] timer_active,
    // [4] move_complete, [19:5] target_rpm, [23:20] zero
    output logic [sspg_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sspg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sspg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    sspg_pkg::ctrl_cmd_t  cmd;
    sspg_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    sspg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sspg_dp
    #(
        .PERIOD_WIDTH     (PERIOD_WIDTH),
        .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule
